@@ sv/cfc_pkg.sv @@
// shared types, constants and helper functions for the framed blob checker
// no dependencies; imported by checksummed_frame_checker_unit and cfc_checker
package cfc_pkg;

	// default width of the saturating byte counter
	localparam int CFC_COUNT_BITS = 41;

	// field widths
	localparam int SEED_W    = 64;
	localparam int MAXLEN_W  = 40;
	localparam int VERSION_W = 32;
	localparam int CFG_IDX_W = 2;

	// blob layout
	localparam int MAGIC_BYTES   = 8;
	localparam int VERSION_END   = 12;
	localparam int HEADER_BYTES  = 20;
	localparam int TRAILER_BYTES = 8;
	localparam int MIN_BLOB      = HEADER_BYTES + TRAILER_BYTES + 8;

	// register reset values
	localparam logic [SEED_W-1:0]    SEED_RESET    = 64'hCBF2_9CE4_8422_2325;
	localparam logic [MAXLEN_W-1:0]  MAXLEN_RESET  = 40'h00_4000_0000;
	localparam logic [VERSION_W-1:0] VERSION_RESET = 32'd1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HASH_SEED = 2'd0,
		REG_MAX_LEN   = 2'd1,
		REG_VERSION   = 2'd2
	} cfg_reg_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_SHORT        = 3'd1,
		ST_MAGIC        = 3'd2,
		ST_VERSION      = 3'd3,
		ST_TOO_LARGE    = 3'd4,
		ST_LEN_MISMATCH = 3'd5,
		ST_CHECKSUM     = 3'd6
	} status_t;

	// expected magic byte at header position 0..7
	function automatic logic [7:0] magic_byte(input logic [2:0] pos);
		logic [7:0] b;
		unique case (pos)
			3'd0: b = 8'h46;
			3'd1: b = 8'h46;
			3'd2: b = 8'h52;
			3'd3: b = 8'h53;
			3'd4: b = 8'h54;
			3'd5: b = 8'h30;
			3'd6: b = 8'h30;
			3'd7: b = 8'h31;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// multiply by the 64-bit fnv prime 2^40 + 0x1b3, modulo 2^64, as shifts and adds
	function automatic logic [63:0] fnv_mul(input logic [63:0] x);
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

@@ sv/checksummed_frame_checker_unit.sv @@
// top level of the framed blob checker: header parse, fnv-1a-64 hash, trailer check
// depends on cfc_pkg; cfc_checker binds to it from its own file
//
// Takes a blob one byte per beat on the byte channel (data_byte, last_byte)
// and, on the beat that carries last_byte, delivers one result beat with a
// status and the payload length from the header. The blob is an 8-byte magic,
// a 32-bit little-endian version, a 64-bit little-endian payload length, the
// payload and an 8-byte little-endian fnv-1a-64 checksum over everything
// before it. Status is checked in the order too short, bad magic, bad version,
// payload too large, length mismatch, checksum mismatch; a too-short blob
// reports payload length 0. Throughput is one byte per clock unless byte_stall
// holds a last byte: the byte goes into an input register and all of its work
// (header field capture, one fnv step with the prime as a shift-and-add, and
// the final status compare) goes from there into the frame state and the result
// register. result_valid rises as the input register passes on the
// last byte. byte_stall rises only when a last byte sits in the input register
// while the previous result is still held by result_stall; ordinary bytes
// keep flowing behind a waiting result. hash_seed is taken on the first byte
// of each blob. The byte counter is COUNT_BITS wide and saturates; a blob
// that drives it to its top value reports a length mismatch. Configuration
// writes go through cfg_wr_en / cfg_index / cfg_data, are meant for idle
// periods, and a write to the unused index is ignored.
module checksummed_frame_checker_unit
	import cfc_pkg::*;
#(
	parameter int COUNT_BITS = CFC_COUNT_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SEED_W-1:0]    cfg_data,
	// byte channel
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	// result channel
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [2:0]           status,
	output logic [63:0]          payload_length
);

	// position constants at counter width
	localparam logic [COUNT_BITS-1:0] CNT_MAX     = '1;
	localparam logic [COUNT_BITS-1:0] CNT_MAGIC   = COUNT_BITS'(MAGIC_BYTES);
	localparam logic [COUNT_BITS-1:0] CNT_VER_END = COUNT_BITS'(VERSION_END);
	localparam logic [COUNT_BITS-1:0] CNT_HDR     = COUNT_BITS'(HEADER_BYTES);
	localparam logic [COUNT_BITS-1:0] CNT_MIN     = COUNT_BITS'(MIN_BLOB);
	localparam logic [63:0]           FRAME_OVH   = 64'(HEADER_BYTES + TRAILER_BYTES);

	// configuration registers
	logic [SEED_W-1:0]    hash_seed_q;
	logic [MAXLEN_W-1:0]  max_len_q;
	logic [VERSION_W-1:0] exp_version_q;

	// input register
	logic       byte_valid_s1;
	logic [7:0] data_byte_s1;
	logic       last_byte_s1;

	// frame state
	logic [COUNT_BITS-1:0] count_q;
	logic [63:0]           hash_q;
	logic [31:0]           version_q;
	logic [63:0]           length_q;
	logic [63:0]           trailer_q;
	logic                  magic_bad_q;

	// next frame state and status
	logic [COUNT_BITS-1:0] count_d;
	logic [63:0]           hash_base;
	logic [63:0]           hash_d;
	logic [31:0]           version_d;
	logic [63:0]           length_d;
	logic [63:0]           trailer_d;
	logic                  magic_bad_d;
	logic                  hash_en;
	logic [2:0]            len_pos;
	status_t               status_d;

	// result register
	logic       result_valid_q;
	status_t    status_q;
	logic [63:0] payload_length_q;

	logic s1_go;

	// a last byte must wait while the previous result is held downstream
	assign s1_go      = byte_valid_s1 && !(last_byte_s1 && result_valid_q && result_stall);
	assign byte_stall = byte_valid_s1 && !s1_go;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_seed_q   <= SEED_RESET;
			max_len_q     <= MAXLEN_RESET;
			exp_version_q <= VERSION_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_HASH_SEED: hash_seed_q   <= cfg_data;
				REG_MAX_LEN:   max_len_q     <= cfg_data[MAXLEN_W-1:0];
				REG_VERSION:   exp_version_q <= cfg_data[VERSION_W-1:0];
				default: ; // unused index, write dropped
			endcase
		end
	end

	// input register: takes a beat whenever it is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			byte_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			data_byte_s1 <= data_byte;
			last_byte_s1 <= last_byte;
		end
	end

	// per-byte work
	always_comb begin
		// magic compare on the first eight bytes
		magic_bad_d = magic_bad_q;
		if (count_q < CNT_MAGIC && data_byte_s1 != magic_byte(count_q[2:0])) begin
			magic_bad_d = 1'b1;
		end

		// version bytes 8..11, little endian
		version_d = version_q;
		if (count_q >= CNT_MAGIC && count_q < CNT_VER_END) begin
			version_d = version_q | ({24'b0, data_byte_s1} << {count_q[1:0], 3'b000});
		end

		// length bytes 12..19, little endian
		len_pos  = count_q[2:0] - 3'd4;
		length_d = length_q;
		if (count_q >= CNT_VER_END && count_q < CNT_HDR) begin
			length_d = length_q | ({56'b0, data_byte_s1} << {len_pos, 3'b000});
		end

		// hash covers header and the declared payload, seeded on the first byte
		hash_base = (count_q == '0) ? hash_seed_q : hash_q;
		hash_en   = (count_q < CNT_HDR) || (64'(count_q - CNT_HDR) < length_q);
		hash_d    = hash_en ? fnv_mul(hash_base ^ {56'b0, data_byte_s1}) : hash_base;

		// last eight bytes seen form the trailer
		trailer_d = {data_byte_s1, trailer_q[63:8]};

		// saturating count
		count_d = (count_q == CNT_MAX) ? count_q : count_q + 1'b1;

		// status in check order
		priority if (count_d < CNT_MIN) begin
			status_d = ST_SHORT;
		end else if (magic_bad_d) begin
			status_d = ST_MAGIC;
		end else if (version_d != exp_version_q) begin
			status_d = ST_VERSION;
		end else if (length_d > 64'(max_len_q)) begin
			status_d = ST_TOO_LARGE;
		end else if (count_d == CNT_MAX || 64'(count_d) != length_d + FRAME_OVH) begin
			status_d = ST_LEN_MISMATCH;
		end else if (hash_d != trailer_d) begin
			status_d = ST_CHECKSUM;
		end else begin
			status_d = ST_OK;
		end
	end

	// frame state: cleared after the last byte of each blob
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			version_q   <= '0;
			length_q    <= '0;
			trailer_q   <= '0;
			magic_bad_q <= 1'b0;
		end else if (s1_go) begin
			if (last_byte_s1) begin
				count_q     <= '0;
				version_q   <= '0;
				length_q    <= '0;
				trailer_q   <= '0;
				magic_bad_q <= 1'b0;
			end else begin
				count_q     <= count_d;
				version_q   <= version_d;
				length_q    <= length_d;
				trailer_q   <= trailer_d;
				magic_bad_q <= magic_bad_d;
			end
		end
	end

	// running hash is reseeded on the first byte, so it needs no reset
	always_ff @(posedge clk) begin
		if (s1_go) begin
			hash_q <= hash_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_go && last_byte_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_byte_s1) begin
			status_q         <= status_d;
			payload_length_q <= (status_d == ST_SHORT) ? 64'd0 : length_d;
		end
	end

	assign result_valid   = result_valid_q;
	assign status         = status_q;
	assign payload_length = payload_length_q;

endmodule

@@ sv/cfc_checker.sv @@
// port-level assertions for checksummed_frame_checker_unit, attached by bind
// depends on cfc_pkg for the status codes
module cfc_checker
	import cfc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 byte_stall,
	input logic                 result_valid,
	input logic                 result_stall,
	input logic [2:0]           status,
	input logic [63:0]          payload_length
);

	// a valid result's status is always one of the defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (status == ST_OK || status == ST_SHORT || status == ST_MAGIC ||
			status == ST_VERSION || status == ST_TOO_LARGE ||
			status == ST_LEN_MISMATCH || status == ST_CHECKSUM))
		else $error("undefined status code");

	// a too-short blob carries no header length
	a_short_len: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == ST_SHORT) |-> payload_length == 64'd0)
		else $error("short blob with nonzero payload length");

	// input back-pressure only comes from a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (result_valid && result_stall))
		else $error("byte stall without a held result");

	// a held result keeps its contents
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=>
			(result_valid && $stable(status) && $stable(payload_length)))
		else $error("held result changed");

endmodule

bind checksummed_frame_checker_unit cfc_checker u_cfc_checker (.*);
